/* sv/ppc_pkg.sv */
// types, constants and codes shared by the pump pressure controller
package ppc_pkg;

    localparam int PRESSURE_WIDTH = 16;
    localparam int TIME_WIDTH     = 32;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = (TIME_WIDTH > PRESSURE_WIDTH) ? TIME_WIDTH : PRESSURE_WIDTH;

    typedef logic [PRESSURE_WIDTH-1:0] pressure_t;
    typedef logic [TIME_WIDTH-1:0]     ms_t;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_LOW_PRESSURE       = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_HIGH_PRESSURE      = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_EMERGENCY_PRESSURE = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_START_DELAY_MS     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_MAX_RUN_MS         = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_COOLDOWN_MS        = 3'd5;

    localparam pressure_t RST_LOW_PRESSURE       = PRESSURE_WIDTH'(150);
    localparam pressure_t RST_HIGH_PRESSURE      = PRESSURE_WIDTH'(300);
    localparam pressure_t RST_EMERGENCY_PRESSURE = PRESSURE_WIDTH'(50);
    localparam ms_t       RST_START_DELAY_MS     = TIME_WIDTH'(3000);
    localparam ms_t       RST_MAX_RUN_MS         = TIME_WIDTH'(600000);
    localparam ms_t       RST_COOLDOWN_MS        = TIME_WIDTH'(60000);

    localparam logic [1:0] PHASE_CODE_OFF   = 2'd0;
    localparam logic [1:0] PHASE_CODE_DELAY = 2'd1;
    localparam logic [1:0] PHASE_CODE_ON    = 2'd2;
    localparam logic [1:0] PHASE_CODE_ESTOP = 2'd3;

    localparam logic [1:0] EVENT_NONE      = 2'd0;
    localparam logic [1:0] EVENT_RUNTIME   = 2'd1;
    localparam logic [1:0] EVENT_EMERGENCY = 2'd2;
    localparam logic [1:0] EVENT_COOLDOWN  = 2'd3;

    typedef enum logic [3:0] {
        PH_OFF   = 4'b0001,
        PH_DELAY = 4'b0010,
        PH_ON    = 4'b0100,
        PH_ESTOP = 4'b1000
    } phase_t;

    typedef struct packed {
        pressure_t pressure;
        ms_t       now_ms;
    } in_item_t;

    typedef struct packed {
        logic       pump_on;
        logic [1:0] phase_code;
        logic [1:0] event_code;
    } out_item_t;

endpackage

/* sv/pump_pressure_controller.sv */
// pump pressure controller: sample register, phase logic and result register
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  in       | in_valid / in_ready       | in_data   (pressure, now_ms)
//  out      | out_valid / out_ready     | out_data  (pump_on, phase_code, event_code)
//  cfg      | cfg_we                    | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_ready is high
// the sample register feeds the phase compare/subtract logic, which loads the result register
// in_ready is high while the sample or result register is empty or the result is being taken
// reset: pump off, phase off, thresholds and timers at their defaults
module pump_pressure_controller
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ppc_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ppc_pkg::out_item_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [ppc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [ppc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import ppc_pkg::*;

    pressure_t low_pressure_reg;
    pressure_t high_pressure_reg;
    pressure_t emergency_pressure_reg;
    ms_t       start_delay_ms_reg;
    ms_t       max_run_ms_reg;
    ms_t       cooldown_ms_reg;

    in_item_t  sample_reg;
    logic      sample_valid_reg;
    out_item_t result_reg;
    logic      result_valid_reg;

    phase_t    phase_reg;
    phase_t    phase_next;
    ms_t       phase_start_reg;
    ms_t       phase_start_next;
    logic      drive_reg;
    logic      drive_next;
    logic [1:0] event_next;
    logic [1:0] phase_code_next;

    ms_t  elapsed;
    logic is_low;
    logic is_high;
    logic is_emerg;
    logic advance;

    assign advance   = sample_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready  = !sample_valid_reg || !result_valid_reg || out_ready;
    assign out_valid = result_valid_reg;
    assign out_data  = result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_pressure_reg       <= RST_LOW_PRESSURE;
            high_pressure_reg      <= RST_HIGH_PRESSURE;
            emergency_pressure_reg <= RST_EMERGENCY_PRESSURE;
            start_delay_ms_reg     <= RST_START_DELAY_MS;
            max_run_ms_reg         <= RST_MAX_RUN_MS;
            cooldown_ms_reg        <= RST_COOLDOWN_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOW_PRESSURE:       low_pressure_reg       <= cfg_data[PRESSURE_WIDTH-1:0];
                REG_HIGH_PRESSURE:      high_pressure_reg      <= cfg_data[PRESSURE_WIDTH-1:0];
                REG_EMERGENCY_PRESSURE: emergency_pressure_reg <= cfg_data[PRESSURE_WIDTH-1:0];
                REG_START_DELAY_MS:     start_delay_ms_reg     <= cfg_data[TIME_WIDTH-1:0];
                REG_MAX_RUN_MS:         max_run_ms_reg         <= cfg_data[TIME_WIDTH-1:0];
                REG_COOLDOWN_MS:        cooldown_ms_reg        <= cfg_data[TIME_WIDTH-1:0];
                default:                ;
            endcase
        end
    end

    // sample register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            sample_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= in_data;
        end
    end

    // phase logic
    assign elapsed  = sample_reg.now_ms - phase_start_reg;
    assign is_low   = sample_reg.pressure <= low_pressure_reg;
    assign is_high  = sample_reg.pressure >= high_pressure_reg;
    assign is_emerg = sample_reg.pressure < emergency_pressure_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        phase_start_next = phase_start_reg;
        drive_next       = drive_reg;
        event_next       = EVENT_NONE;
        unique case (phase_reg)
            PH_OFF:
            begin
                if (is_low)
                begin
                    phase_next       = PH_DELAY;
                    phase_start_next = sample_reg.now_ms;
                end
            end
            PH_DELAY:
            begin
                if (!is_low)
                begin
                    phase_next       = PH_OFF;
                    phase_start_next = sample_reg.now_ms;
                end
                else if (elapsed >= start_delay_ms_reg)
                begin
                    drive_next       = 1'b1;
                    phase_next       = PH_ON;
                    phase_start_next = sample_reg.now_ms;
                end
            end
            PH_ON:
            begin
                if (elapsed >= max_run_ms_reg)
                begin
                    drive_next       = 1'b0;
                    phase_next       = PH_ESTOP;
                    phase_start_next = sample_reg.now_ms;
                    event_next       = EVENT_RUNTIME;
                end
                else if (is_emerg)
                begin
                    drive_next       = 1'b0;
                    phase_next       = PH_ESTOP;
                    phase_start_next = sample_reg.now_ms;
                    event_next       = EVENT_EMERGENCY;
                end
                else if (is_high)
                begin
                    drive_next       = 1'b0;
                    phase_next       = PH_OFF;
                    phase_start_next = sample_reg.now_ms;
                end
            end
            PH_ESTOP:
            begin
                if (elapsed >= cooldown_ms_reg)
                begin
                    phase_next       = PH_OFF;
                    phase_start_next = sample_reg.now_ms;
                    event_next       = EVENT_COOLDOWN;
                end
            end
            default:
            begin
                phase_next = PH_OFF;
            end
        endcase
    end

    always_comb
    begin
        unique case (phase_next)
            PH_OFF:   phase_code_next = PHASE_CODE_OFF;
            PH_DELAY: phase_code_next = PHASE_CODE_DELAY;
            PH_ON:    phase_code_next = PHASE_CODE_ON;
            PH_ESTOP: phase_code_next = PHASE_CODE_ESTOP;
            default:  phase_code_next = PHASE_CODE_OFF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_OFF;
            phase_start_reg  <= '0;
            drive_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg       <= phase_next;
                phase_start_reg <= phase_start_next;
                drive_reg       <= drive_next;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.pump_on    <= drive_next;
            result_reg.phase_code <= phase_code_next;
            result_reg.event_code <= event_next;
        end
    end

endmodule

/* tb/testbench.sv */
// self-checking testbench for the pump pressure controller
`timescale 1ns / 100ps

module testbench;

    import ppc_pkg::*;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_7 = 3'd7;
    localparam int DRAIN_LIMIT = 20000;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    in_item_t                  in_data;
    logic                      out_valid;
    logic                      out_ready;
    out_item_t                 out_data;
    logic                      cfg_we;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    // predictor copy of the registers and controller state
    pressure_t  thr_low;
    pressure_t  thr_high;
    pressure_t  thr_emerg;
    ms_t        delay_ms;
    ms_t        run_limit_ms;
    ms_t        cool_ms;
    logic [1:0] pump_phase;
    ms_t        phase_entry_ms;
    logic       pump_drive;

    out_item_t  expected_q[$];
    out_item_t  want_item;
    int         error_count;
    bit         idle_on;
    int         hold_req;
    int         hold_seen;
    int         hold_len;
    ms_t        now_cursor;
    int         regime;
    int         regime_left;

    pump_pressure_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic out_item_t predict_pump(in_item_t s);
        out_item_t  r;
        ms_t        elapsed;
        logic       at_low;
        logic       at_high;
        logic       below_emerg;
        logic [1:0] ev;
        elapsed     = s.now_ms - phase_entry_ms;
        at_low      = s.pressure <= thr_low;
        at_high     = s.pressure >= thr_high;
        below_emerg = s.pressure < thr_emerg;
        ev          = EVENT_NONE;
        case (pump_phase)
            PHASE_CODE_OFF:
            begin
                if (at_low)
                begin
                    pump_phase     = PHASE_CODE_DELAY;
                    phase_entry_ms = s.now_ms;
                end
            end
            PHASE_CODE_DELAY:
            begin
                if (!at_low)
                begin
                    pump_phase     = PHASE_CODE_OFF;
                    phase_entry_ms = s.now_ms;
                end
                else if (elapsed >= delay_ms)
                begin
                    pump_drive     = 1'b1;
                    pump_phase     = PHASE_CODE_ON;
                    phase_entry_ms = s.now_ms;
                end
            end
            PHASE_CODE_ON:
            begin
                if (elapsed >= run_limit_ms)
                begin
                    pump_drive     = 1'b0;
                    pump_phase     = PHASE_CODE_ESTOP;
                    phase_entry_ms = s.now_ms;
                    ev             = EVENT_RUNTIME;
                end
                else if (below_emerg)
                begin
                    pump_drive     = 1'b0;
                    pump_phase     = PHASE_CODE_ESTOP;
                    phase_entry_ms = s.now_ms;
                    ev             = EVENT_EMERGENCY;
                end
                else if (at_high)
                begin
                    pump_drive     = 1'b0;
                    pump_phase     = PHASE_CODE_OFF;
                    phase_entry_ms = s.now_ms;
                end
            end
            default:
            begin
                if (elapsed >= cool_ms)
                begin
                    pump_phase     = PHASE_CODE_OFF;
                    phase_entry_ms = s.now_ms;
                    ev             = EVENT_COOLDOWN;
                end
            end
        endcase
        r.pump_on    = pump_drive;
        r.phase_code = pump_phase;
        r.event_code = ev;
        return r;
    endfunction

    // result checking and expectation capture
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report_error($sformatf("result with nothing expected: %p", out_data));
                else
                begin
                    want_item = expected_q.pop_front();
                    if (out_data.pump_on !== want_item.pump_on)
                        report_error($sformatf("pump_on got %b want %b",
                                               out_data.pump_on, want_item.pump_on));
                    if (out_data.phase_code !== want_item.phase_code)
                        report_error($sformatf("phase_code got %0d want %0d",
                                               out_data.phase_code, want_item.phase_code));
                    if (out_data.event_code !== want_item.event_code)
                        report_error($sformatf("event_code got %0d want %0d",
                                               out_data.event_code, want_item.event_code));
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_pump(in_data));
        end
    end

    // receiver side: random stalls plus requested long hold-offs
    initial
    begin
        hold_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            out_ready <= (idle_on && $urandom_range(0, 99) < 29) ? 1'b0 : 1'b1;
        end
    end

    task automatic send_item(input pressure_t p, input ms_t t);
        in_item_t item;
        int       gap;
        item.pressure = p;
        item.now_ms   = t;
        gap = (idle_on && $urandom_range(0, 99) < 29) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        int cycles;
        cycles = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            cycles++;
        end
        while (expected_q.size() != 0 && cycles < DRAIN_LIMIT);
        if (expected_q.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_q.size()));
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_LOW_PRESSURE:       thr_low      = data[PRESSURE_WIDTH-1:0];
            REG_HIGH_PRESSURE:      thr_high     = data[PRESSURE_WIDTH-1:0];
            REG_EMERGENCY_PRESSURE: thr_emerg    = data[PRESSURE_WIDTH-1:0];
            REG_START_DELAY_MS:     delay_ms     = data[TIME_WIDTH-1:0];
            REG_MAX_RUN_MS:         run_limit_ms = data[TIME_WIDTH-1:0];
            REG_COOLDOWN_MS:        cool_ms      = data[TIME_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // upper bits of pressure writes carry junk, spare indexes must be ignored
    task automatic apply_config(input pressure_t lo, input pressure_t hi, input pressure_t em,
                                input ms_t dly, input ms_t run, input ms_t cool);
        logic [CFG_DATA_WIDTH-1:0] d;
        d = $urandom();
        d[PRESSURE_WIDTH-1:0] = lo;
        write_reg(REG_LOW_PRESSURE, d);
        d = $urandom();
        d[PRESSURE_WIDTH-1:0] = hi;
        write_reg(REG_HIGH_PRESSURE, d);
        d = $urandom();
        d[PRESSURE_WIDTH-1:0] = em;
        write_reg(REG_EMERGENCY_PRESSURE, d);
        write_reg(REG_START_DELAY_MS, dly);
        write_reg(REG_MAX_RUN_MS, run);
        write_reg(REG_COOLDOWN_MS, cool);
        write_reg(REG_SPARE_6, $urandom());
        write_reg(REG_SPARE_7, $urandom());
        cfg_we <= 1'b0;
    endtask

    function automatic ms_t random_ms();
        return ($urandom_range(0, 99) < 85) ? ms_t'($urandom_range(0, 40)) : ms_t'($urandom());
    endfunction

    // pressure follows short regimes so the controller walks through full cycles
    function automatic pressure_t next_pressure();
        int r;
        int v;
        if (regime_left == 0)
        begin
            regime      = $urandom_range(0, 4);
            regime_left = $urandom_range(2, 16);
        end
        regime_left--;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 8)
            return '1;
        case (regime)
            0: v = (thr_low >= thr_emerg) ?
                   int'(thr_emerg) + $urandom_range(0, int'(thr_low) - int'(thr_emerg)) :
                   int'(thr_low);
            1: v = int'(thr_high) + $urandom_range(0, 16'hFFFF - int'(thr_high));
            2: v = (thr_emerg == 0) ? 0 : $urandom_range(0, int'(thr_emerg) - 1);
            3:
            begin
                case ($urandom_range(0, 2))
                    0: v = int'(thr_low);
                    1: v = int'(thr_high);
                    default: v = int'(thr_emerg);
                endcase
                v = v + $urandom_range(0, 2) - 1;
            end
            default: v = $urandom_range(0, 16'hFFFF);
        endcase
        return pressure_t'(v);
    endfunction

    // mostly small steps, some large jumps, some steps backwards
    function automatic ms_t next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            now_cursor = now_cursor + ms_t'($urandom_range(0, 6));
        else if (r < 88)
            now_cursor = now_cursor + ms_t'($urandom_range(7, 120));
        else if (r < 94)
            now_cursor = now_cursor + ms_t'($urandom());
        else
            now_cursor = now_cursor - ms_t'($urandom_range(1, 60));
        return now_cursor;
    endfunction

    task automatic test_reset_defaults();
        idle_on = 1'b1;
        send_item(16'd150, 32'd100);
        send_item(16'd150, 32'd3099);
        send_item(16'd150, 32'd3100);
        send_item(16'd49, 32'd3200);
        send_item(16'd300, 32'd3300);
        send_item(16'd0, 32'd63300);
        send_item(16'd151, 32'd63301);
        send_item(16'd0, 32'd63400);
        send_item(16'd0, 32'd66400);
        send_item(16'hFFFF, 32'd66401);
        send_item(16'd100, 32'd70000);
        send_item(16'd100, 32'd73000);
        // run time and low pressure together
        send_item(16'd10, 32'd673000);
        drain_results();
    endtask

    task automatic test_corner_configs();
        // inverted thresholds, zero delays: high and emergency at once
        apply_config(16'hFFFF, 16'h0000, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
        repeat (4) send_item(16'd100, 32'd5000);
        drain_results();
        // zero run limit trips on the first step spent on
        apply_config(16'h0000, 16'hFFFF, 16'h0000, 32'd0, 32'd0, 32'd0);
        repeat (4) send_item(16'd0, 32'hFFFF_FFFF);
        drain_results();
        // time wrap, then time going backwards
        apply_config(RST_LOW_PRESSURE, RST_HIGH_PRESSURE, RST_EMERGENCY_PRESSURE,
                     RST_START_DELAY_MS, RST_MAX_RUN_MS, RST_COOLDOWN_MS);
        send_item(16'd150, 32'hFFFF_FF00);
        send_item(16'd150, 32'h0000_0100);
        send_item(16'd150, 32'hFFFF_FE00);
        drain_results();
    endtask

    task automatic test_backpressure();
        apply_config(16'd150, 16'd300, 16'd50, 32'd5, 32'd40, 32'd10);
        idle_on  = 1'b1;
        hold_len = 80;
        hold_req++;
        repeat (40) send_item(next_pressure(), next_time());
        drain_results();
        repeat (40) send_item(next_pressure(), next_time());
        drain_results();
    endtask

    task automatic test_random_traffic();
        pressure_t em;
        pressure_t lo;
        pressure_t hi;
        now_cursor = 32'hFFFF_FE00;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: apply_config('0, '0, '0, '0, '0, '0);
                1: apply_config('1, '1, '1, '1, '1, '1);
                default:
                begin
                    em = pressure_t'($urandom_range(0, 200));
                    lo = pressure_t'(em + $urandom_range(0, 300));
                    hi = pressure_t'(lo + $urandom_range(1, 500));
                    if ($urandom_range(0, 4) == 0)
                    begin
                        em = pressure_t'($urandom());
                        lo = pressure_t'($urandom());
                        hi = pressure_t'($urandom());
                    end
                    apply_config(lo, hi, em, random_ms(), random_ms(), random_ms());
                end
            endcase
            idle_on = (ph != 4);
            repeat (130) send_item(next_pressure(), next_time());
            drain_results();
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        error_count  = 0;
        idle_on      = 1'b1;
        hold_req     = 0;
        hold_len     = 0;
        regime       = 0;
        regime_left  = 0;
        now_cursor   = '0;
        thr_low      = RST_LOW_PRESSURE;
        thr_high     = RST_HIGH_PRESSURE;
        thr_emerg    = RST_EMERGENCY_PRESSURE;
        delay_ms     = RST_START_DELAY_MS;
        run_limit_ms = RST_MAX_RUN_MS;
        cool_ms      = RST_COOLDOWN_MS;
        pump_phase   = PHASE_CODE_OFF;
        phase_entry_ms = '0;
        pump_drive   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_corner_configs();
        test_backpressure();
        test_random_traffic();

        drain_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* pump_pressure_controller.f */
sv/ppc_pkg.sv
sv/pump_pressure_controller.sv
tb/testbench.sv
